@@ design/slpd_pkg.sv @@
// Shared types, constants and bit helpers for the spectral line depacketiser.
package slpd_pkg;

  localparam int MAX_LINES      = 1024;
  localparam int WORDS_PER_LINE = 7680;

  localparam int POS_W = 14;
  localparam logic [POS_W-1:0] POS_MAX         = 14'h3FFF;
  localparam logic [POS_W-1:0] POS_MARKER      = 14'd9;
  localparam logic [POS_W-1:0] POS_LINE_HIGH   = 14'd10;
  localparam logic [POS_W-1:0] POS_LINE_LOW    = 14'd11;
  localparam logic [POS_W-1:0] POS_ALIGN       = 14'd16;
  localparam logic [POS_W-1:0] POS_PACK_START  = 14'd16;
  localparam logic [POS_W-1:0] POS_PACK_SHIFT  = 14'd18;
  localparam logic [12:0]      COL_SHIFT       = 13'd14;

  localparam logic [13:0] WIDTH_WIDE   = 14'd12096;
  localparam logic [13:0] WIDTH_NARROW = 14'd7296;
  localparam logic [9:0]  HEIGHT_FULL  = 10'd748;
  localparam logic [9:0]  HEIGHT_HALF  = 10'd374;

  localparam logic [1:0] MODE_FULL_NARROW = 2'd3;
  localparam logic [1:0] MODE_HALF_WIDE   = 2'd2;

  localparam logic [15:0] WIN_A_LO = 16'd50;
  localparam logic [15:0] WIN_A_HI = 16'd70;
  localparam logic [15:0] WIN_B_LO = 16'd500;
  localparam logic [15:0] WIN_B_HI = 16'd520;
  localparam logic [15:0] WIN_C_LO = 16'd700;
  localparam logic [15:0] WIN_C_HI = 16'd720;

  localparam logic [15:0] HIST_MAX = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_TWO
  } pack_phase_e;

  // One decoded event handed from the byte front end to the result stage.
  typedef struct packed {
    logic        pixel_valid;
    logic [12:0] column_index;
    logic [15:0] pixel_value;
    logic        packet_done;
    logic [15:0] line_number;
    logic [1:0]  marker;
  } slpd_cmd_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [11:0] rev12(input logic [11:0] v);
    logic [11:0] r;
    for (int i = 0; i < 12; i++) begin
      r[i] = v[11-i];
    end
    return r;
  endfunction

endpackage

@@ design/slpd_front.sv @@
// Byte front end: header capture, alignment detection and 12-bit word packing.
module slpd_front import slpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic      last_of_packet_i,
  input  logic      queue_full_i,
  output logic      cmd_valid_o,
  output slpd_cmd_t cmd_o
);

  logic [POS_W-1:0] pos_q, pos_d, pos_n;
  logic [1:0]       marker_q, marker_d, marker_n;
  logic [15:0]      line_q, line_d, line_n;
  logic             mis_q, mis_d, mis_n;
  logic [11:0]      residue_q, residue_d, residue_n;
  pack_phase_e      phase_q, phase_d, phase_n;
  logic [12:0]      wp_q, wp_d, wp_n;

  logic [7:0]  rbyte;
  logic        pack_en;
  logic        have_word;
  logic [11:0] word;
  logic [11:0] word_rev;
  logic        take_word;
  logic        pixel;
  logic        accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign rbyte      = rev8(data_byte_i);

  always_comb begin
    marker_n = (pos_q == POS_MARKER) ? data_byte_i[1:0] : marker_q;
    line_n   = line_q;
    if (pos_q == POS_LINE_HIGH) begin
      line_n = {data_byte_i, line_q[7:0]};
    end else if (pos_q == POS_LINE_LOW) begin
      line_n = {line_q[15:8], data_byte_i};
    end
    mis_n   = (pos_q == POS_ALIGN) ? (|rbyte[6:0]) : mis_q;
    pack_en = pos_q >= (mis_n ? POS_PACK_SHIFT : POS_PACK_START);
  end

  // Packing phase: three reversed bytes make two 12-bit words.
  always_comb begin
    unique case (phase_q)
      PH_IDLE: phase_n = pack_en ? PH_ONE : PH_IDLE;
      PH_ONE:  phase_n = pack_en ? PH_TWO : PH_ONE;
      PH_TWO:  phase_n = pack_en ? PH_IDLE : PH_TWO;
      default: phase_n = PH_IDLE;
    endcase
  end

  always_comb begin
    have_word = 1'b0;
    word      = '0;
    residue_n = residue_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (pack_en) begin
          residue_n = {4'd0, rbyte};
        end
      end
      PH_ONE: begin
        if (pack_en) begin
          word      = {residue_q[7:0], rbyte[7:4]};
          residue_n = {8'd0, rbyte[3:0]};
          have_word = 1'b1;
        end
      end
      PH_TWO: begin
        if (pack_en) begin
          word      = {residue_q[3:0], rbyte};
          residue_n = '0;
          have_word = 1'b1;
        end
      end
      default: begin
        residue_n = '0;
      end
    endcase
  end

  assign take_word = have_word && ({1'b0, wp_q} < 14'(WORDS_PER_LINE));
  assign pixel     = take_word && ({1'b0, line_n} < 17'(MAX_LINES));
  assign wp_n      = take_word ? wp_q + 13'd1 : wp_q;
  assign pos_n     = (pos_q == POS_MAX) ? pos_q : pos_q + 14'd1;
  assign word_rev  = rev12(word);

  always_comb begin
    cmd_o.pixel_valid  = pixel;
    cmd_o.column_index = '0;
    cmd_o.pixel_value  = '0;
    if (pixel) begin
      cmd_o.column_index = wp_q + (mis_n ? COL_SHIFT : 13'd0);
      // The reversed word shifted left overflows 16 bits exactly when its top bit is set.
      cmd_o.pixel_value  = word[0] ? 16'hFFFF : {word_rev[10:0], 5'd0};
    end
    cmd_o.packet_done  = last_of_packet_i;
    cmd_o.line_number  = line_n;
    cmd_o.marker       = marker_n;
  end

  assign cmd_valid_o = accept & (pixel | last_of_packet_i);

  always_comb begin
    pos_d     = pos_q;
    marker_d  = marker_q;
    line_d    = line_q;
    mis_d     = mis_q;
    residue_d = residue_q;
    phase_d   = phase_q;
    wp_d      = wp_q;
    if (accept) begin
      if (last_of_packet_i) begin
        pos_d     = '0;
        marker_d  = '0;
        line_d    = '0;
        mis_d     = 1'b0;
        residue_d = '0;
        phase_d   = PH_IDLE;
        wp_d      = '0;
      end else begin
        pos_d     = pos_n;
        marker_d  = marker_n;
        line_d    = line_n;
        mis_d     = mis_n;
        residue_d = residue_n;
        phase_d   = phase_n;
        wp_d      = wp_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      marker_q  <= '0;
      line_q    <= '0;
      mis_q     <= 1'b0;
      residue_q <= '0;
      phase_q   <= PH_IDLE;
      wp_q      <= '0;
    end else begin
      pos_q     <= pos_d;
      marker_q  <= marker_d;
      line_q    <= line_d;
      mis_q     <= mis_d;
      residue_q <= residue_d;
      phase_q   <= phase_d;
      wp_q      <= wp_d;
    end
  end

`ifndef SYNTHESIS
  a_packet_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_of_packet_i |=> pos_q == '0 && phase_q == PH_IDLE && wp_q == '0)
    else $error("packet state not cleared after final byte");
  a_word_only_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_word |-> pos_q >= POS_PACK_START)
    else $error("word formed inside the header");
`endif

endmodule

@@ design/slpd_queue.sv @@
// Short register queue between the byte front end and the result stage.
module slpd_queue import slpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  slpd_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output slpd_cmd_t cmd_o
);

  slpd_cmd_t              entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + QUEUE_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + QUEUE_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("event pushed into a full queue");
`endif

endmodule

@@ design/slpd_back.sv @@
// Result stage: end-of-packet mode tracking, histogram and output register.
module slpd_back import slpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  slpd_cmd_t   cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pixel_valid_o,
  output logic [9:0]  line_index_o,
  output logic [12:0] column_index_o,
  output logic [15:0] pixel_value_o,
  output logic        packet_done_o,
  output logic [1:0]  detected_mode_o,
  output logic [13:0] image_width_o,
  output logic [9:0]  image_height_o,
  output logic [10:0] line_count_o
);

  logic        out_valid_q, out_valid_d;
  logic        pixel_q;
  logic [9:0]  line_idx_q;
  logic [12:0] col_q;
  logic [15:0] val_q;
  logic        done_q;

  logic [10:0] highest_q, highest_d;
  logic [1:0]  mode_q, mode_d;
  logic [13:0] width_q, width_d;
  logic [9:0]  height_q, height_d;
  logic [15:0] hist_q [4];
  logic [15:0] hist_d [4];

  logic [1:0]  best;
  logic        in_window;
  logic [15:0] lnum;

  assign pop_o       = cmd_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_d = pop_o | (out_valid_q & out_stall_i);
  assign lnum        = cmd_i.line_number;

  assign in_window = (lnum > WIN_A_LO && lnum < WIN_A_HI) ||
                     (lnum > WIN_B_LO && lnum < WIN_B_HI) ||
                     (lnum > WIN_C_LO && lnum < WIN_C_HI);

  // Majority marker of earlier packets; the first of equal counts wins.
  always_comb begin
    best = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (hist_q[k] > hist_q[best]) begin
        best = 2'(k);
      end
    end
  end

  always_comb begin
    highest_d = highest_q;
    mode_d    = mode_q;
    width_d   = width_q;
    height_d  = height_q;
    for (int k = 0; k < 4; k++) begin
      hist_d[k] = hist_q[k];
    end
    if (pop_o && cmd_i.packet_done) begin
      if ({5'd0, highest_q} <= lnum && {1'b0, lnum} < 17'(MAX_LINES)) begin
        highest_d = 11'(lnum + 16'd1);
      end
      if (in_window) begin
        mode_d = best;
        if (best == MODE_FULL_NARROW) begin
          width_d  = WIDTH_NARROW;
          height_d = HEIGHT_FULL;
        end else if (best == MODE_HALF_WIDE) begin
          width_d  = WIDTH_WIDE;
          height_d = HEIGHT_HALF;
        end
      end
      if (hist_q[cmd_i.marker] != HIST_MAX) begin
        hist_d[cmd_i.marker] = hist_q[cmd_i.marker] + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      highest_q   <= '0;
      mode_q      <= '0;
      width_q     <= WIDTH_WIDE;
      height_q    <= HEIGHT_FULL;
      for (int k = 0; k < 4; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      highest_q   <= highest_d;
      mode_q      <= mode_d;
      width_q     <= width_d;
      height_q    <= height_d;
      for (int k = 0; k < 4; k++) begin
        hist_q[k] <= hist_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pixel_q    <= cmd_i.pixel_valid;
      line_idx_q <= cmd_i.pixel_valid ? cmd_i.line_number[9:0] : 10'd0;
      col_q      <= cmd_i.column_index;
      val_q      <= cmd_i.pixel_value;
      done_q     <= cmd_i.packet_done;
    end
  end

  // The mode state only moves together with a new result, so it matches the shown result.
  assign out_valid_o     = out_valid_q;
  assign pixel_valid_o   = pixel_q;
  assign line_index_o    = line_idx_q;
  assign column_index_o  = col_q;
  assign pixel_value_o   = val_q;
  assign packet_done_o   = done_q;
  assign detected_mode_o = mode_q;
  assign image_width_o   = width_q;
  assign image_height_o  = height_q;
  assign line_count_o    = highest_q;

`ifndef SYNTHESIS
  a_mode3_geometry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_FULL_NARROW |-> width_q == WIDTH_NARROW && height_q == HEIGHT_FULL)
    else $error("geometry does not match mode three");
  a_state_moves_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && cmd_i.packet_done) |=> $stable(mode_q) && $stable(highest_q))
    else $error("mode state changed without a final-byte result");
`endif

endmodule

@@ design/spectral_line_packet_depacketizer_unit.sv @@
// Top level of the spectral line packet depacketiser.
//
// Input channel: one raw payload byte per word (data_byte_i) with
// last_of_packet_i high on the final byte, handshaked by in_valid_i and
// in_stall_o. Output channel: one result word for each byte that forms a
// pixel or ends a packet, handshaked by out_valid_o and out_stall_i.
// A byte is taken each cycle unless in_stall_o is high; the accepting edge
// writes its event into the event queue, and a later edge loads it into the
// output register once out_stall_i allows. Sustained rate is one byte per cycle
// while neither side stalls, set by the single byte-wide packer in the front
// end and the one-result-per-cycle output
// register. A four-entry event queue separates the two sides, so a stalled
// receiver first fills the queue and only then raises in_stall_o; results
// are held unchanged while out_stall_i is high. Bytes that make no result
// never wait on the receiver unless the queue is full.
// Reset clears packet state, the marker histogram and line count, and sets
// the geometry to 12096 by 748 with mode 0; no clearing pass is needed.
module spectral_line_packet_depacketizer_unit import slpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pixel_valid_o,
  output logic [9:0]  line_index_o,
  output logic [12:0] column_index_o,
  output logic [15:0] pixel_value_o,
  output logic        packet_done_o,
  output logic [1:0]  detected_mode_o,
  output logic [13:0] image_width_o,
  output logic [9:0]  image_height_o,
  output logic [10:0] line_count_o
);

  logic      push;
  slpd_cmd_t push_cmd;
  logic      queue_full;
  logic      pop;
  logic      queue_valid;
  slpd_cmd_t queue_cmd;

  slpd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_of_packet_i (last_of_packet_i),
    .queue_full_i     (queue_full),
    .cmd_valid_o      (push),
    .cmd_o            (push_cmd)
  );

  slpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .cmd_o      (queue_cmd)
  );

  slpd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_i           (queue_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_valid_o   (pixel_valid_o),
    .line_index_o    (line_index_o),
    .column_index_o  (column_index_o),
    .pixel_value_o   (pixel_value_o),
    .packet_done_o   (packet_done_o),
    .detected_mode_o (detected_mode_o),
    .image_width_o   (image_width_o),
    .image_height_o  (image_height_o),
    .line_count_o    (line_count_o)
  );

endmodule
